// ===== hdl/rd128_pkg.sv =====
// Shared types and constants for the 128-bit restoring divider.
package rd128_pkg;

  localparam int unsigned HALF_W = 64;
  localparam int unsigned WORD_W = 2 * HALF_W;
  localparam int unsigned STEPS  = WORD_W;
  localparam int unsigned CNT_W  = $clog2(STEPS);

  typedef struct packed {
    logic [HALF_W-1:0] dividend_high;
    logic [HALF_W-1:0] dividend_low;
    logic [HALF_W-1:0] divisor_high;
    logic [HALF_W-1:0] divisor_low;
  } in_t;

  typedef struct packed {
    logic [HALF_W-1:0] quotient_high;
    logic [HALF_W-1:0] quotient_low;
    logic [HALF_W-1:0] remainder_high;
    logic [HALF_W-1:0] remainder_low;
    logic              divide_by_zero;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

endpackage

// ===== hdl/restoring_divider_128_core.sv =====
// A new request is taken only after the previous result; the 128-step
//   shift-subtract loop of the datapath (one quotient bit per cycle) sets the pace.
// busy is high from the accept until the result cycle ends; out_valid is a
//   one-cycle strobe and the receiver cannot stall it.
// Reset (rst_n low, synchronous) returns the sequencer to idle; data regs hold.
module restoring_divider_128_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rd128_pkg::in_t    in_req,
  output logic              out_valid,
  output rd128_pkg::out_t   out_rsp
);

  rd128_pkg::dp_cmd_t cmd;

  // Sequencer: idle -> 128 steps -> one result cycle
  rd128_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Datapath: plain long division over all 128 dividend bits. Leading zero
  // steps leave the remainder and quotient unchanged, so no alignment search
  // is needed and the result matches the aligned form bit for bit.
  rd128_dp u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

`ifndef SYNTHESIS
  // An accepted request keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // The result strobe lasts exactly one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // A result only appears while a request is in flight.
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  // The datapath never loads and steps in the same cycle.
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.step))
    else $error("load and step together");
`endif

endmodule

// ===== hdl/rd128_ctrl.sv =====
// Sequencer for the divider: load, one step per quotient bit, result strobe.
module rd128_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_valid,
  output rd128_pkg::dp_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [rd128_pkg::CNT_W-1:0] LAST_STEP =
    rd128_pkg::CNT_W'(rd128_pkg::STEPS - 1);

  logic [1:0]                  state_r, state_nxt;
  logic [rd128_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.load  = 1'b0;
    cmd.step  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

endmodule

// ===== hdl/rd128_dp.sv =====
// Datapath for the divider: partial remainder, quotient and divisor registers.
module rd128_dp (
  input  logic               clk,
  input  rd128_pkg::dp_cmd_t cmd,
  input  rd128_pkg::in_t     in_req,
  output rd128_pkg::out_t    out_rsp
);

  localparam int unsigned W = rd128_pkg::WORD_W;
  localparam int unsigned H = rd128_pkg::HALF_W;

  logic [W-1:0] rem_r, rem_nxt;
  logic [W-1:0] quo_r, quo_nxt;
  logic [W-1:0] den_r;
  logic         zero_r;
  logic [W:0]   trial;
  logic [W:0]   diff;
  logic         fits;

  // Shift next dividend bit into the partial remainder, try the subtract.
  assign trial = {rem_r, quo_r[W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = ~diff[W];

  always_comb begin
    rem_nxt = fits ? diff[W-1:0] : trial[W-1:0];
    quo_nxt = {quo_r[W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r  <= '0;
      quo_r  <= {in_req.dividend_high, in_req.dividend_low};
      den_r  <= {in_req.divisor_high, in_req.divisor_low};
      zero_r <= ({in_req.divisor_high, in_req.divisor_low} == '0);
    end else if (cmd.step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  // Zero divisor: flag it and force all data fields to zero.
  always_comb begin
    out_rsp.quotient_high  = zero_r ? '0 : quo_r[W-1:H];
    out_rsp.quotient_low   = zero_r ? '0 : quo_r[H-1:0];
    out_rsp.remainder_high = zero_r ? '0 : rem_r[W-1:H];
    out_rsp.remainder_low  = zero_r ? '0 : rem_r[H-1:0];
    out_rsp.divide_by_zero = zero_r;
  end

endmodule

// ===== verif/tb_restoring_divider_128_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the 128-bit restoring divider core.
module tb_restoring_divider_128_core;

  // Core latency from the accepting edge to the result edge.
  localparam int unsigned LATENCY      = 129;
  localparam int unsigned RESET_CYCLES = 11;
  // Longest idle gap the sender inserts before a request.
  localparam int unsigned MAX_GAP      = 300;
  // Quiet cycles allowed before the watchdog gives up; the limit is built from the divide latency and the longest gap.
  localparam int unsigned STALL_LIMIT  = 4 * (LATENCY + MAX_GAP);

  localparam logic [127:0] MAX_WORD = {128{1'b1}};
  localparam logic [127:0] TOP_ONE  = 128'd1 << 127;
  localparam logic [127:0] HALF_ONE = 128'd1 << 64;
  localparam logic [127:0] LOW_ONES = {64'd0, {64{1'b1}}};
  localparam logic [127:0] PAT_5    = {32{4'h5}};
  localparam logic [127:0] PAT_A    = {32{4'hA}};

  logic           clk   = 1'b0;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  rd128_pkg::in_t in_req = '0;
  logic           busy;
  logic           out_valid;
  rd128_pkg::out_t out_rsp;

  // Expected results, oldest request first.
  rd128_pkg::out_t pending_results[$];
  rd128_pkg::out_t oldest_result;
  int unsigned     mismatch_count = 0;
  int unsigned     quiet_cycles   = 0;
  // Chance, in percent, that the sender idles before a request.
  int unsigned     idle_pct       = 12;

  restoring_divider_128_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Position of the highest set bit; caller passes a nonzero value.
  function automatic int unsigned top_bit(input logic [127:0] v);
    int unsigned pos;
    pos = 0;
    for (int i = 0; i < 128; i++)
      if (v[i]) pos = i;
    return pos;
  endfunction

  // Shift-subtract division with special cases that give the core's results:
  // zero divisor flags an error with zero outputs, a larger divisor leaves
  // the dividend as remainder, equal operands give quotient one.
  function automatic rd128_pkg::out_t divide_wide(input rd128_pkg::in_t req);
    logic [127:0]    num;
    logic [127:0]    den;
    logic [127:0]    quo;
    int unsigned     shift;
    rd128_pkg::out_t rsp;
    num = {req.dividend_high, req.dividend_low};
    den = {req.divisor_high, req.divisor_low};
    quo = '0;
    rsp = '0;
    if (den == '0) begin
      rsp.divide_by_zero = 1'b1;
      num = '0;
    end else if (num == den) begin
      quo = 128'd1;
      num = '0;
    end else if (num > den) begin
      // Align divisor's top bit with the dividend's, then one restoring
      // step per bit down to bit 0.
      shift = top_bit(num) - top_bit(den);
      den = den << shift;
      for (int i = 0; i <= int'(shift); i++) begin
        quo = quo << 1;
        if (num >= den) begin
          num = num - den;
          quo[0] = 1'b1;
        end
        den = den >> 1;
      end
    end
    rsp.quotient_high  = quo[127:64];
    rsp.quotient_low   = quo[63:0];
    rsp.remainder_high = num[127:64];
    rsp.remainder_low  = num[63:0];
    return rsp;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic logic [127:0] rand_word();
    return {$urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  // Random value with exactly n significant bits (n in 1..128).
  function automatic logic [127:0] rand_sized(input int unsigned n);
    logic [127:0] v;
    v = rand_word();
    if (n < 128) v = v & ((128'd1 << n) - 128'd1);
    v[n-1] = 1'b1;
    return v;
  endfunction

  // Send one divide request. start is left high after the accept so that a
  // back-to-back request does not drop and raise it in one time step. A gap
  // lowers it first and counts its idle cycles from the first cycle in
  // which the core is free again, so the whole gap is seen at the input.
  task automatic send_request(input logic [127:0] num, input logic [127:0] den);
    rd128_pkg::in_t req;
    int unsigned    gap;
    req = {num, den};  // field order: dividend hi/lo, divisor hi/lo
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, MAX_GAP);
      start <= 1'b0;
      // First edge seen with busy low ends the first idle cycle.
      do @(posedge clk); while (busy !== 1'b0);
      repeat (gap - 1) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= req;
    // Values read right after the edge are the ones the core sampled.
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(divide_wide(req));
  endtask

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------

  task automatic check_half(input string name, input logic [63:0] want,
                            input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // out_valid is a one-cycle strobe; each strobe is taken at the edge that
  // ends it and matched against the oldest request.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request outstanding: expected none actual %h",
                 $time, out_rsp);
        mismatch_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        check_half("quotient_high", oldest_result.quotient_high, out_rsp.quotient_high);
        check_half("quotient_low", oldest_result.quotient_low, out_rsp.quotient_low);
        check_half("remainder_high", oldest_result.remainder_high,
                   out_rsp.remainder_high);
        check_half("remainder_low", oldest_result.remainder_low, out_rsp.remainder_low);
        if (out_rsp.divide_by_zero !== oldest_result.divide_by_zero) begin
          $display("%0t: divide_by_zero mismatch: expected %b actual %b", $time,
                   oldest_result.divide_by_zero, out_rsp.divide_by_zero);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: any accepted request or result clears the count.
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Zero divisor, with small, large and split-half dividends.
  task automatic test_zero_divisor();
    send_request('0, '0);
    send_request(MAX_WORD, '0);
    send_request(HALF_ONE, '0);
    send_request(rand_word(), '0);
  endtask

  // Divisor above dividend: the dividend comes back as remainder.
  task automatic test_divisor_above();
    send_request('0, 128'd1);
    send_request('0, MAX_WORD);
    send_request(MAX_WORD - 128'd1, MAX_WORD);
    send_request(128'd1, MAX_WORD);
    send_request(LOW_ONES, HALF_ONE);
  endtask

  // Equal operands.
  task automatic test_equal_operands();
    send_request(128'd1, 128'd1);
    send_request(MAX_WORD, MAX_WORD);
    send_request(TOP_ONE, TOP_ONE);
    send_request(PAT_5, PAT_5);
  endtask

  // Field extremes, longest alignment and carries across the halves.
  task automatic test_extremes();
    send_request(MAX_WORD, 128'd1);
    send_request(MAX_WORD, MAX_WORD - 128'd1);
    send_request(TOP_ONE, 128'd1);
    send_request(MAX_WORD, TOP_ONE);
    send_request(HALF_ONE, 128'd1);
    send_request(MAX_WORD, HALF_ONE);
    send_request(LOW_ONES, 128'd3);
    send_request(128'd3, 128'd2);
    send_request(PAT_A, PAT_5);
    send_request(TOP_ONE | 128'd5, 128'd3);
  endtask

  // Random operands spread over the divider's cases. Most requests pick
  // operand widths so the alignment shift covers the whole range.
  task automatic test_random_mixed(input int unsigned count);
    logic [127:0] num;
    logic [127:0] den;
    int unsigned  pick;
    int unsigned  nd;
    logic [127:0] delta;
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        num = rand_word();
        den = '0;
      end else if (pick < 15) begin
        // divisor above dividend
        den = rand_sized($urandom_range(1, 128));
        num = rand_word() % den;
      end else if (pick < 20) begin
        num = rand_sized($urandom_range(1, 128));
        den = num;
      end else if (pick < 30) begin
        num = rand_word();
        den = rand_word();
      end else if (pick < 80) begin
        nd  = $urandom_range(1, 128);
        num = rand_sized(nd);
        den = rand_sized($urandom_range(1, nd));
      end else if (pick < 90) begin
        // small divisor, long quotient
        num = rand_sized($urandom_range(100, 128));
        den = rand_sized($urandom_range(1, 8));
      end else if (pick < 95) begin
        // operands one to three apart
        den   = rand_sized($urandom_range(1, 128));
        delta = 128'($urandom_range(1, 3));
        num   = den + delta;
        if (num < den) num = den - delta;
      end else begin
        if ($urandom_range(1) == 1) begin
          num = rand_word();
          den = 128'd1 << $urandom_range(0, 127);
        end else begin
          num = MAX_WORD;
          den = rand_sized($urandom_range(1, 128));
        end
      end
      send_request(num, den);
    end
  endtask

  // Requests offered with no idling, so each follows its predecessor's
  // result as soon as busy falls.
  task automatic test_back_to_back(input int unsigned count);
    idle_pct = 0;
    test_random_mixed(count);
    idle_pct = 12;
  endtask

  initial begin
    // Synchronous reset held for a fixed number of edges.
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_zero_divisor();
    test_divisor_above();
    test_equal_operands();
    test_extremes();
    test_random_mixed(1300);
    test_back_to_back(350);

    // Drain, then keep watching past the divide latency for stray results.
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== restoring_divider_128_core.f =====
hdl/rd128_pkg.sv
hdl/rd128_ctrl.sv
hdl/rd128_dp.sv
hdl/restoring_divider_128_core.sv
verif/tb_restoring_divider_128_core.sv
